// ===== src/assert_macros.svh =====
// Assertion helpers for the projection RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/lpcp_pkg.sv =====
`default_nettype none
package lpcp_pkg;
    localparam int PT_W   = 20;
    localparam int TAG_W  = 8;
    localparam int PIX_W  = 24;
    localparam int CFG_W  = 64;
    localparam int DIM_W  = 14;
    localparam int EXT_W  = 16;
    localparam int INT_W  = 21;
    localparam int PROD_W = EXT_W + PT_W;     // extrinsic product
    localparam int CAM_W  = 38;               // camera coordinate
    localparam int LO_W   = 18;               // low split of camera coordinate
    localparam int HI_W   = CAM_W - LO_W;
    localparam int PPL_W  = INT_W + LO_W + 1;
    localparam int PPH_W  = INT_W + HI_W;
    localparam int PRJ_W  = 61;               // projected coordinate
    localparam int REM_W  = PRJ_W + 4;        // |16*p| magnitude
    localparam int DIV_W  = PRJ_W - 1;        // positive depth magnitude
    localparam int NSTEP  = PIX_W;            // quotient bits, one per stage

    typedef enum logic [2:0] {
        REG_EXT0 = 3'd0,
        REG_EXT1 = 3'd1,
        REG_EXT2 = 3'd2,
        REG_INT0 = 3'd3,
        REG_INT1 = 3'd4,
        REG_INT2 = 3'd5,
        REG_WIDTH = 3'd6,
        REG_HEIGHT = 3'd7
    } cfg_index_t;

    localparam logic [CFG_W-1:0] EXT0_RST = 64'd4096;
    localparam logic [CFG_W-1:0] EXT1_RST = 64'd268435456;
    localparam logic [CFG_W-1:0] EXT2_RST = 64'd17592186044416;
    localparam logic [CFG_W-1:0] INT0_RST = 64'd16;
    localparam logic [CFG_W-1:0] INT1_RST = 64'd33554432;
    localparam logic [CFG_W-1:0] INT2_RST = 64'd70368744177664;
    localparam logic [DIM_W-1:0] WIDTH_RST  = 14'd1920;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 14'd1080;
endpackage
`default_nettype wire

// ===== src/lidar_point_camera_projection.sv =====
// Lidar point to camera pixel projection.
// Input channel: in_valid/in_stall with point_x/y/z (1/1024 m) and cluster_tag.
// Output channel: out_valid/out_stall with pixel_u/v (1/16 px), tag_out, in_image.
// A point whose projected depth is zero or negative produces no output.
// Configuration: cfg_write/cfg_index/cfg_data, one register per write, taken
// at the clock edge; write only while the pipeline is empty.
// Throughput: one point per cycle unless out_stall holds the pipeline. The
// pipeline is a 9-multiplier extrinsic stage, a sum stage, an 18-multiplier
// intrinsic stage, a sum stage, a sign/overflow stage, 24 restoring-divide
// stages (one quotient bit each, u and v in parallel) and a saturate/bounds
// stage that is the output register.
// Reset clears all valid bits and loads the identity transform, identity
// intrinsics and a 1920 x 1080 image.
// When out_stall is high with a result waiting, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
`default_nettype none
module lidar_point_camera_projection (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [lpcp_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [lpcp_pkg::PT_W-1:0] point_x,
    input  wire logic signed [lpcp_pkg::PT_W-1:0] point_y,
    input  wire logic signed [lpcp_pkg::PT_W-1:0] point_z,
    input  wire logic [lpcp_pkg::TAG_W-1:0]    cluster_tag,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [lpcp_pkg::PIX_W-1:0]  pixel_u,
    output logic signed [lpcp_pkg::PIX_W-1:0]  pixel_v,
    output logic [lpcp_pkg::TAG_W-1:0]         tag_out,
    output logic                               in_image
);
    import lpcp_pkg::*;
`include "assert_macros.svh"

    logic [CFG_W-1:0] ext_reg [3];
    logic [CFG_W-1:0] intr_reg [3];
    logic [DIM_W-1:0] width_reg, height_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg[0]  <= EXT0_RST;
            ext_reg[1]  <= EXT1_RST;
            ext_reg[2]  <= EXT2_RST;
            intr_reg[0] <= INT0_RST;
            intr_reg[1] <= INT1_RST;
            intr_reg[2] <= INT2_RST;
            width_reg   <= WIDTH_RST;
            height_reg  <= HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_EXT0:   ext_reg[0]  <= cfg_data;
                REG_EXT1:   ext_reg[1]  <= cfg_data;
                REG_EXT2:   ext_reg[2]  <= cfg_data;
                REG_INT0:   intr_reg[0] <= cfg_data;
                REG_INT1:   intr_reg[1] <= cfg_data;
                REG_INT2:   intr_reg[2] <= cfg_data;
                REG_WIDTH:  width_reg   <= cfg_data[DIM_W-1:0];
                REG_HEIGHT: height_reg  <= cfg_data[DIM_W-1:0];
                default:    width_reg   <= width_reg;
            endcase
        end
    end

    // global advance: pipeline moves unless a finished result is held
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // stage 1: extrinsic products
    logic                      s1_vld_reg;
    logic [TAG_W-1:0]          s1_tag_reg;
    logic signed [PROD_W-1:0]  s1_prod_reg [3][3];
    logic signed [EXT_W-1:0]   s1_t_reg [3];
    logic signed [PT_W-1:0]    pt [3];
    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tag_reg <= cluster_tag;
            for (int i = 0; i < 3; i++)
            begin
                s1_t_reg[i] <= $signed(ext_reg[i][3*EXT_W +: EXT_W]);
                for (int j = 0; j < 3; j++)
                    s1_prod_reg[i][j] <= $signed(ext_reg[i][j*EXT_W +: EXT_W]) * pt[j];
            end
        end
    end

    // stage 2: camera coordinates
    logic                     s2_vld_reg;
    logic [TAG_W-1:0]         s2_tag_reg;
    logic signed [CAM_W-1:0]  s2_cam_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_tag_reg <= s1_tag_reg;
            for (int i = 0; i < 3; i++)
                s2_cam_reg[i] <= CAM_W'(s1_prod_reg[i][0]) + CAM_W'(s1_prod_reg[i][1])
                               + CAM_W'(s1_prod_reg[i][2])
                               + CAM_W'($signed({s1_t_reg[i], 10'b0}));
        end
    end

    // stage 3: intrinsic partial products, camera value split low/high
    logic                     s3_vld_reg;
    logic [TAG_W-1:0]         s3_tag_reg;
    logic signed [PPL_W-1:0]  s3_lo_reg [3][3];
    logic signed [PPH_W-1:0]  s3_hi_reg [3][3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_tag_reg <= s2_tag_reg;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    s3_lo_reg[i][j] <= $signed(intr_reg[i][j*INT_W +: INT_W])
                                     * $signed({1'b0, s2_cam_reg[j][LO_W-1:0]});
                    s3_hi_reg[i][j] <= $signed(intr_reg[i][j*INT_W +: INT_W])
                                     * $signed(s2_cam_reg[j][CAM_W-1:LO_W]);
                end
        end
    end

    // stage 4: projected coordinates
    logic                     s4_vld_reg;
    logic [TAG_W-1:0]         s4_tag_reg;
    logic signed [PRJ_W-1:0]  s4_prj_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_tag_reg <= s3_tag_reg;
            for (int i = 0; i < 3; i++)
                s4_prj_reg[i] <= (PRJ_W'(s3_hi_reg[i][0]) <<< LO_W)
                               + (PRJ_W'(s3_hi_reg[i][1]) <<< LO_W)
                               + (PRJ_W'(s3_hi_reg[i][2]) <<< LO_W)
                               + PRJ_W'(s3_lo_reg[i][0]) + PRJ_W'(s3_lo_reg[i][1])
                               + PRJ_W'(s3_lo_reg[i][2]);
        end
    end

    // stage 5: depth test, magnitudes, quotient overflow check
    logic [REM_W-1:0] mag_u, mag_v;
    logic [DIV_W-1:0] dvs;
    logic             dpos;
    assign dpos  = !s4_prj_reg[2][PRJ_W-1] && (s4_prj_reg[2] != '0);
    assign dvs   = s4_prj_reg[2][DIV_W-1:0];
    assign mag_u = {(s4_prj_reg[0][PRJ_W-1] ? PRJ_W'(-s4_prj_reg[0])
                                             : PRJ_W'(s4_prj_reg[0])), 4'b0};
    assign mag_v = {(s4_prj_reg[1][PRJ_W-1] ? PRJ_W'(-s4_prj_reg[1])
                                             : PRJ_W'(s4_prj_reg[1])), 4'b0};

    logic             dv_vld_reg [NSTEP+1];
    logic [TAG_W-1:0] dv_tag_reg [NSTEP+1];
    logic [DIV_W-1:0] dv_d_reg   [NSTEP+1];
    logic [REM_W-1:0] dv_ru_reg  [NSTEP+1];
    logic [REM_W-1:0] dv_rv_reg  [NSTEP+1];
    logic [PIX_W-1:0] dv_qu_reg  [NSTEP+1];
    logic [PIX_W-1:0] dv_qv_reg  [NSTEP+1];
    logic             dv_nu_reg  [NSTEP+1];
    logic             dv_nv_reg  [NSTEP+1];
    logic             dv_ou_reg  [NSTEP+1];
    logic             dv_ov_reg  [NSTEP+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_tag_reg[0] <= s4_tag_reg;
            dv_d_reg[0]   <= dvs;
            dv_ru_reg[0]  <= mag_u;
            dv_rv_reg[0]  <= mag_v;
            dv_qu_reg[0]  <= '0;
            dv_qv_reg[0]  <= '0;
            dv_nu_reg[0]  <= s4_prj_reg[0][PRJ_W-1];
            dv_nv_reg[0]  <= s4_prj_reg[1][PRJ_W-1];
            dv_ou_reg[0]  <= (mag_u >> PIX_W) >= REM_W'(dvs);
            dv_ov_reg[0]  <= (mag_v >> PIX_W) >= REM_W'(dvs);
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar k = 0; k < NSTEP; k++)
    begin : g_div
        localparam int B = NSTEP - 1 - k;
        logic take_u, take_v;
        assign take_u = (dv_ru_reg[k] >> B) >= REM_W'(dv_d_reg[k]);
        assign take_v = (dv_rv_reg[k] >> B) >= REM_W'(dv_d_reg[k]);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_tag_reg[k+1] <= dv_tag_reg[k];
                dv_d_reg[k+1]   <= dv_d_reg[k];
                dv_nu_reg[k+1]  <= dv_nu_reg[k];
                dv_nv_reg[k+1]  <= dv_nv_reg[k];
                dv_ou_reg[k+1]  <= dv_ou_reg[k];
                dv_ov_reg[k+1]  <= dv_ov_reg[k];
                dv_ru_reg[k+1]  <= take_u ? dv_ru_reg[k] - (REM_W'(dv_d_reg[k]) << B)
                                          : dv_ru_reg[k];
                dv_rv_reg[k+1]  <= take_v ? dv_rv_reg[k] - (REM_W'(dv_d_reg[k]) << B)
                                          : dv_rv_reg[k];
                dv_qu_reg[k+1]  <= dv_qu_reg[k] | (PIX_W'(take_u) << B);
                dv_qv_reg[k+1]  <= dv_qv_reg[k] | (PIX_W'(take_v) << B);
            end
        end
    end

    // final stage: floor for negatives, saturation, bounds test
    logic [PIX_W:0]   cu, cv;
    logic [PIX_W-1:0] su, sv;
    logic             iu, iv;
    localparam logic [PIX_W-1:0] SMAX = {1'b0, {(PIX_W-1){1'b1}}};
    localparam logic [PIX_W-1:0] SMIN = {1'b1, {(PIX_W-1){1'b0}}};
    localparam logic [PIX_W:0]   NLIM = {2'b01, {(PIX_W-1){1'b0}}};

    always_comb
    begin
        cu = {1'b0, dv_qu_reg[NSTEP]} + (PIX_W+1)'(dv_ru_reg[NSTEP] != '0);
        cv = {1'b0, dv_qv_reg[NSTEP]} + (PIX_W+1)'(dv_rv_reg[NSTEP] != '0);
        if (dv_nu_reg[NSTEP])
            su = (dv_ou_reg[NSTEP] || cu > NLIM) ? SMIN : PIX_W'(-cu);
        else
            su = (dv_ou_reg[NSTEP] || dv_qu_reg[NSTEP][PIX_W-1]) ? SMAX
                                                                  : dv_qu_reg[NSTEP];
        if (dv_nv_reg[NSTEP])
            sv = (dv_ov_reg[NSTEP] || cv > NLIM) ? SMIN : PIX_W'(-cv);
        else
            sv = (dv_ov_reg[NSTEP] || dv_qv_reg[NSTEP][PIX_W-1]) ? SMAX
                                                                  : dv_qv_reg[NSTEP];
        iu = !dv_nu_reg[NSTEP] && !dv_ou_reg[NSTEP]
             && (dv_qu_reg[NSTEP] < {width_reg, 4'b0});
        iv = !dv_nv_reg[NSTEP] && !dv_ov_reg[NSTEP]
             && (dv_qv_reg[NSTEP] < {height_reg, 4'b0});
    end

    logic             out_vld_reg;
    logic [PIX_W-1:0] u_reg, v_reg;
    logic [TAG_W-1:0] tag_reg;
    logic             inimg_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u_reg     <= su;
            v_reg     <= sv;
            tag_reg   <= dv_tag_reg[NSTEP];
            inimg_reg <= iu && iv;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            for (int k = 0; k <= NSTEP; k++)
                dv_vld_reg[k] <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg    <= in_valid;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            s4_vld_reg    <= s3_vld_reg;
            dv_vld_reg[0] <= s4_vld_reg && dpos;
            for (int k = 0; k < NSTEP; k++)
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            out_vld_reg   <= dv_vld_reg[NSTEP];
        end
    end

    assign out_valid = out_vld_reg;
    assign pixel_u   = $signed(u_reg);
    assign pixel_v   = $signed(v_reg);
    assign tag_out   = tag_reg;
    assign in_image  = inimg_reg;

    // checks
    `ASSERT_IMPLY(a_rem_below_div, clk, rst_n,
        dv_vld_reg[NSTEP] && !dv_ou_reg[NSTEP],
        dv_ru_reg[NSTEP] < REM_W'(dv_d_reg[NSTEP]), "divider remainder not below divisor")
    `ASSERT_IMPLY(a_inimg_nonneg, clk, rst_n, out_valid && in_image,
        !pixel_u[PIX_W-1] && !pixel_v[PIX_W-1], "in-image point has negative pixel")
    `ASSERT_IMPLY(a_inimg_bound, clk, rst_n, out_valid && in_image,
        (u_reg < {width_reg, 4'b0}) && (v_reg < {height_reg, 4'b0}),
        "in-image point outside configured size")
endmodule
`default_nettype wire

// ===== tb/tb_lidar_point_camera_projection.sv =====
`default_nettype none
module tb_lidar_point_camera_projection;
    import lpcp_pkg::*;

    typedef struct {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic signed [PT_W-1:0] z;
        logic [TAG_W-1:0]       tag;
    } lidar_point_t;

    typedef struct {
        logic signed [PIX_W-1:0] u;
        logic signed [PIX_W-1:0] v;
        logic [TAG_W-1:0]        tag;
        logic                    in_frame;
    } pixel_t;

    typedef logic signed [127:0] wide_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_write = 1'b0;
    logic [2:0]                    cfg_index = 3'd0;
    logic [CFG_W-1:0]              cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [PT_W-1:0]        point_x = '0;
    logic signed [PT_W-1:0]        point_y = '0;
    logic signed [PT_W-1:0]        point_z = '0;
    logic [TAG_W-1:0]              cluster_tag = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [PIX_W-1:0]       pixel_u;
    logic signed [PIX_W-1:0]       pixel_v;
    logic [TAG_W-1:0]              tag_out;
    logic                          in_image;

    // shadow copy of the register file
    logic [CFG_W-1:0] ext_row [3];
    logic [CFG_W-1:0] int_row [3];
    logic [DIM_W-1:0] img_w;
    logic [DIM_W-1:0] img_h;

    lidar_point_t pending_points [$];
    pixel_t       expected_pixels [$];
    int           errors = 0;
    int           n_points = 0;
    int           n_pixels = 0;
    int           n_behind = 0;
    int           n_inside = 0;
    int           in_gap = 0;
    int           out_gap = 0;
    bit           idle_en = 1'b1;

    lidar_point_camera_projection dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .cluster_tag (cluster_tag),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_u     (pixel_u),
        .pixel_v     (pixel_v),
        .tag_out     (tag_out),
        .in_image    (in_image)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // floor division, positive divisor
    function automatic wide_t floor_div(wide_t n, wide_t d);
        if (n >= 0)
            return n / d;
        return -((-n + d - 1) / d);
    endfunction

    function automatic logic signed [PIX_W-1:0] clamp_pixel(wide_t q);
        if (q > 8388607)
            return 24'sh7FFFFF;
        if (q < -8388608)
            return 24'sh800000;
        return q[PIX_W-1:0];
    endfunction

    // camera transform, intrinsics and divide; returns 0 when depth <= 0
    function automatic bit project_point(lidar_point_t p, output pixel_t r);
        wide_t pt [3];
        wide_t cam [3];
        wide_t prj [3];
        wide_t e;
        wide_t k;
        wide_t qu;
        wide_t qv;
        wide_t w16;
        wide_t h16;
        pt[0] = p.x;
        pt[1] = p.y;
        pt[2] = p.z;
        for (int i = 0; i < 3; i++)
        begin
            e = $signed(ext_row[i][48 +: EXT_W]);
            cam[i] = e * 1024;
            for (int j = 0; j < 3; j++)
            begin
                e = $signed(ext_row[i][16*j +: EXT_W]);
                cam[i] = cam[i] + e * pt[j];
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            prj[i] = 0;
            for (int j = 0; j < 3; j++)
            begin
                k = $signed(int_row[i][21*j +: INT_W]);
                prj[i] = prj[i] + k * cam[j];
            end
        end
        if (prj[2] <= 0)
            return 1'b0;
        qu = floor_div(prj[0] * 16, prj[2]);
        qv = floor_div(prj[1] * 16, prj[2]);
        w16 = img_w;
        w16 = w16 * 16;
        h16 = img_h;
        h16 = h16 * 16;
        r.u = clamp_pixel(qu);
        r.v = clamp_pixel(qv);
        r.tag = p.tag;
        r.in_frame = (qu >= 0) && (qu < w16) && (qv >= 0) && (qv < h16);
        return 1'b1;
    endfunction

    // point driver
    always @(posedge clk or negedge rst_n)
    begin
        lidar_point_t cur;
        lidar_point_t nxt;
        pixel_t px;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                cur.x = point_x;
                cur.y = point_y;
                cur.z = point_z;
                cur.tag = cluster_tag;
                n_points++;
                if (project_point(cur, px))
                    expected_pixels.push_back(px);
                else
                    n_behind++;
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (idle_en && $urandom_range(0, 9) == 0)
                begin
                    in_gap = $urandom_range(0, 6);
                    in_valid <= 1'b0;
                end
                else if (pending_points.size() > 0)
                begin
                    nxt = pending_points.pop_front();
                    point_x <= nxt.x;
                    point_y <= nxt.y;
                    point_z <= nxt.z;
                    cluster_tag <= nxt.tag;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // pixel monitor and output stall
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t ex;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected pixel u=%0d v=%0d tag=%0d in=%0d",
                             $time, pixel_u, pixel_v, tag_out, in_image);
                    errors++;
                end
                else
                begin
                    ex = expected_pixels.pop_front();
                    n_pixels++;
                    if (in_image)
                        n_inside++;
                    if (pixel_u !== ex.u)
                    begin
                        $display("%0t: pixel_u expected %0d actual %0d", $time, ex.u, pixel_u);
                        errors++;
                    end
                    if (pixel_v !== ex.v)
                    begin
                        $display("%0t: pixel_v expected %0d actual %0d", $time, ex.v, pixel_v);
                        errors++;
                    end
                    if (tag_out !== ex.tag)
                    begin
                        $display("%0t: tag_out expected %0d actual %0d", $time, ex.tag, tag_out);
                        errors++;
                    end
                    if (in_image !== ex.in_frame)
                    begin
                        $display("%0t: in_image expected %0d actual %0d",
                                 $time, ex.in_frame, in_image);
                        errors++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else if (idle_en && $urandom_range(0, 9) == 0)
            begin
                out_gap = $urandom_range(0, 6);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic add_point(logic [PT_W-1:0] x, logic [PT_W-1:0] y, logic [PT_W-1:0] z,
                             logic [TAG_W-1:0] tag);
        lidar_point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.tag = tag;
        pending_points.push_back(p);
    endtask

    // hold off until the pipeline has drained, including dropped points
    task automatic drain();
        while (pending_points.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_EXT0: ext_row[0] = val;
            REG_EXT1: ext_row[1] = val;
            REG_EXT2: ext_row[2] = val;
            REG_INT0: int_row[0] = val;
            REG_INT1: int_row[1] = val;
            REG_INT2: int_row[2] = val;
            REG_WIDTH: img_w = val[DIM_W-1:0];
            default: img_h = val[DIM_W-1:0];
        endcase
    endtask

    function automatic logic [15:0] near_q12(int center, int spread);
        return 16'(center + $signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic logic [CFG_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // one register setting per phase: random, plausible camera, or extreme
    task automatic load_setting(int mode, int k);
        logic [CFG_W-1:0] v [8];
        logic [20:0] fx;
        logic [20:0] fy;
        case (mode)
            0:
            begin
                for (int i = 0; i < 8; i++)
                    v[i] = rand64();
            end
            1:
            begin
                v[0] = {near_q12(0, 8000), near_q12(0, 300), near_q12(0, 300),
                        near_q12(4096, 300)};
                v[1] = {near_q12(0, 8000), near_q12(0, 300), near_q12(4096, 300),
                        near_q12(0, 300)};
                v[2] = {near_q12(8192, 8000), near_q12(4096, 300), near_q12(0, 300),
                        near_q12(0, 300)};
                fx = 21'($urandom_range(100, 4000) * 16);
                fy = 21'($urandom_range(100, 4000) * 16);
                v[3] = {1'($urandom), 21'($urandom_range(0, 40000)), 21'd0, fx};
                v[4] = {1'($urandom), 21'($urandom_range(0, 30000)), fy, 21'd0};
                v[5] = {1'($urandom), 21'd16, 21'd0, 21'd0};
                v[6] = 64'($urandom_range(1, 4000));
                v[7] = 64'($urandom_range(1, 3000));
            end
            default:
            begin
                v[0] = (k % 2 == 0) ? 64'h7FFF_7FFF_7FFF_7FFF : 64'h8000_8000_8000_8000;
                v[1] = (k % 2 == 0) ? 64'h8000_7FFF_8000_7FFF : 64'h7FFF_8000_7FFF_8000;
                v[2] = (k % 2 == 0) ? 64'h0000_8000_7FFF_8000 : 64'hFFFF_0001_0001_7FFF;
                v[3] = (k % 2 == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h8000_0100_000F_FFFF;
                v[4] = (k % 2 == 0) ? 64'h0000_0200_0010_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                v[5] = (k % 2 == 0) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h0000_0000_0000_0000;
                // a zero size comes from high bits that the register drops
                v[6] = (k % 2 == 0) ? 64'h3FFF : 64'hFFFF_FFFF_FFFF_C000;
                v[7] = (k % 2 == 0) ? 64'h1 : 64'h3FFF;
            end
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(cfg_index_t'(i), v[i]);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic random_points(int n, int mode);
        logic [PT_W-1:0] z;
        for (int i = 0; i < n; i++)
        begin
            // mostly points in front of the camera for the plausible setting
            if (mode == 1 && $urandom_range(0, 7) != 0)
                z = 20'($urandom_range(1, 100000));
            else
                z = 20'($urandom);
            if ($urandom_range(0, 3) == 0)
                add_point(20'($urandom), 20'($urandom), z, 8'($urandom));
            else
                add_point(20'($signed($urandom_range(0, 60000)) - 30000),
                          20'($signed($urandom_range(0, 60000)) - 30000), z, 8'($urandom));
        end
    endtask

    initial
    begin
        ext_row[0] = EXT0_RST;
        ext_row[1] = EXT1_RST;
        ext_row[2] = EXT2_RST;
        int_row[0] = INT0_RST;
        int_row[1] = INT1_RST;
        int_row[2] = INT2_RST;
        img_w = WIDTH_RST;
        img_h = HEIGHT_RST;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed points under the reset setting: identity camera
        add_point(20'sd100, 20'sd50, 20'sd1000, 8'd0);
        add_point(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 8'hFF);
        add_point(20'sh80000, 20'sh80000, 20'sh7FFFF, 8'h55);
        add_point(20'sh7FFFF, 20'sh80000, 20'sd1, 8'hAA);
        add_point(20'sh80000, 20'sh7FFFF, 20'sd1, 8'd1);
        add_point(20'sd5, 20'sd5, 20'sd0, 8'd2);
        add_point(20'sd5, 20'sd5, 20'sh80000, 8'd3);
        add_point(20'sd5, 20'sd5, -20'sd1, 8'd4);
        add_point(-20'sd1, -20'sd1, 20'sd3, 8'd5);
        add_point(20'sd0, 20'sd0, 20'sd7, 8'd6);
        add_point(20'sd1919, 20'sd1079, 20'sd1, 8'd7);
        add_point(20'sd1920, 20'sd1079, 20'sd1, 8'd8);
        add_point(20'sd1919, 20'sd1080, 20'sd1, 8'd9);
        add_point(20'sd3839, 20'sd2159, 20'sd2, 8'd10);
        add_point(-20'sd1, 20'sd0, 20'sd100, 8'd11);
        add_point(20'sd524287, 20'sd0, 20'sd16, 8'd12);
        add_point(20'sd0, -20'sd524288, 20'sd16, 8'd13);
        add_point(20'sd2, -20'sd7, 20'sd3, 8'd14);
        drain();

        for (int ph = 0; ph < 9; ph++)
        begin
            load_setting(ph % 3, ph / 3);
            if (ph == 8)
                idle_en = 1'b0;
            random_points(ph % 3 == 2 ? 60 : 180, ph % 3);
            drain();
        end

        $display("Projected %0d points: %0d pixels (%0d inside image), %0d behind camera,",
                 n_points, n_pixels, n_inside, n_behind);
        $display("over random, plausible-camera and extreme register settings.");
        if (errors == 0 && expected_pixels.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
